### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Transaction payload types, command, status and register codes shared by the
// allocator modules.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFREE  = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] page_addr;
  } bpa_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] alloc_addr;
  } bpa_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    value;
  } bpa_cfg_t;

  typedef struct packed {
    logic hit;
    logic last;
  } eval_flags_t;

endpackage

### src/bpa_stream_if.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface bpa_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

### src/bpa_map_ram.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator map memory
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module bpa_map_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/bpa_word_eval.sv
// ----------------------------------------------------------------------------
// Bitmap page allocator word evaluator
// Examines one map word: finds the lowest free live page for an allocation,
// or locates the page to release, and forms the updated word.
// ----------------------------------------------------------------------------
module bpa_word_eval import bpa_pkg::*; #(
  parameter int MAP_WORD_BITS = 32,
  parameter int PAGE_W        = 13,
  parameter int BW            = $clog2(MAP_WORD_BITS)
) (
  input  logic                     cmd_i,
  input  logic [MAP_WORD_BITS-1:0] word_i,
  input  logic [PAGE_W-1:0]        word_page_i,
  input  logic [PAGE_W-1:0]        live_pages_i,
  input  logic [PAGE_W-1:0]        free_idx_i,
  output eval_flags_t              flags_o,
  output logic [BW-1:0]            bit_pos_o,
  output logic [MAP_WORD_BITS-1:0] word_o
);

  localparam int EW = PAGE_W + 2;

  logic [EW-1:0]            rem;
  logic [EW-1:0]            free_ofs;
  logic                     a_hit;
  logic [BW-1:0]            a_pos;
  logic                     f_hit;
  logic [BW-1:0]            pos;
  logic [MAP_WORD_BITS-1:0] mask;

  assign rem      = EW'(live_pages_i) - EW'(word_page_i);
  assign free_ofs = EW'(free_idx_i) - EW'(word_page_i);

  always_comb begin
    a_hit = 1'b0;
    a_pos = '0;
    for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
      if (!word_i[j] && (EW'(j) < rem)) begin
        a_hit = 1'b1;
        a_pos = BW'(j);
      end
    end
  end

  assign f_hit = free_ofs < EW'(MAP_WORD_BITS);
  assign pos   = (cmd_i == CMD_FREE) ? free_ofs[BW-1:0] : a_pos;
  assign mask  = MAP_WORD_BITS'(1) << pos;

  assign flags_o.hit  = (cmd_i == CMD_FREE) ? f_hit : a_hit;
  assign flags_o.last = rem <= EW'(MAP_WORD_BITS);
  assign bit_pos_o    = pos;
  assign word_o       = (cmd_i == CMD_FREE) ? (word_i & ~mask) : (word_i | mask);

endmodule

### src/bitmap_page_allocator.sv
// An allocate or a free reads the map word by word, up to the word holding the lowest
// free page (the last live word if none is free) or the released page, then responds;
// a rejected free, or an allocate with no pages configured, goes straight to the response.
// The next request is taken only once the response to the last has been issued.
// Reset clears the control and configuration registers and then sweeps the map memory,
// one word per cycle (all MAP_DEPTH words, 128 by default), before any request is taken.
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit allocator keeping one used bit per 4 KiB page, scanned word by
// word under a small sequencer.
// ----------------------------------------------------------------------------
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int MAX_PAGES     = 4096,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bpa_stream_if.sink   cfg_i,
  bpa_stream_if.sink   req_i,
  bpa_stream_if.source rsp_o
);

  localparam int MAP_DEPTH = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int PAGE_W    = $clog2(MAX_PAGES + 1);
  localparam int EW        = PAGE_W + 2;
  localparam int BW        = $clog2(MAP_WORD_BITS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [ADDR_W-1:0]  base_q;
  logic [COUNT_W-1:0] page_count_q;
  logic               cmd_q, cmd_d;
  logic [PAGE_W-1:0]  live_q, live_d;
  logic [PAGE_W-1:0]  free_idx_q, free_idx_d;
  logic [AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [EW-1:0]      rd_page_q, rd_page_d;
  logic [AW-1:0]      chk_ptr_q, chk_ptr_d;
  logic [PAGE_W-1:0]  chk_page_q, chk_page_d;
  logic               chk_vld_q, chk_vld_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic               rsp_vld_q, rsp_vld_d;
  bpa_rsp_t           rsp_q, rsp_d;

  logic [ADDR_W-1:0]        base_al;
  logic [PAGE_W-1:0]        live_n;
  logic [ADDR_W-1:0]        offset;
  logic [ADDR_W-PAGE_SHIFT-1:0] off_idx;
  logic                     bad_free;
  logic                     req_fire;
  logic                     rd_en;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata;
  logic [MAP_WORD_BITS-1:0] ram_rdata;
  eval_flags_t              flags;
  logic [BW-1:0]            bit_pos;
  logic [MAP_WORD_BITS-1:0] new_word;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  assign base_al  = {base_q[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
  assign live_n   = (32'(page_count_q) > 32'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES)
                                                         : PAGE_W'(page_count_q);
  assign offset   = req_i.data.page_addr - base_al;
  assign off_idx  = offset[ADDR_W-1:PAGE_SHIFT];
  assign bad_free = (req_i.data.page_addr[PAGE_SHIFT-1:0] != '0)
                 || (req_i.data.page_addr < base_al)
                 || (32'(off_idx) >= 32'(live_n));

  assign rd_en = (state_q == S_SCAN) && (rd_page_q < EW'(live_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      page_count_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        CFG_BASE_ADDR:  base_q       <= cfg_i.data.value;
        CFG_PAGE_COUNT: page_count_q <= cfg_i.data.value[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  bpa_map_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_DEPTH),
    .AW    (AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  bpa_word_eval #(
    .MAP_WORD_BITS (MAP_WORD_BITS),
    .PAGE_W        (PAGE_W),
    .BW            (BW)
  ) u_word_eval (
    .cmd_i        (cmd_q),
    .word_i       (ram_rdata),
    .word_page_i  (chk_page_q),
    .live_pages_i (live_q),
    .free_idx_i   (free_idx_q),
    .flags_o      (flags),
    .bit_pos_o    (bit_pos),
    .word_o       (new_word)
  );

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    live_d       = live_q;
    free_idx_d   = free_idx_q;
    rd_ptr_d     = rd_ptr_q;
    rd_page_d    = rd_page_q;
    chk_ptr_d    = chk_ptr_q;
    chk_page_d   = chk_page_q;
    chk_vld_d    = chk_vld_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    rsp_vld_d    = rsp_vld_q && !rsp_o.ready;
    rsp_d        = rsp_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_ptr_q;
    ram_wdata    = new_word;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_ptr_q;
        ram_wdata = '0;
        rd_ptr_d  = rd_ptr_q + AW'(1);
        if (rd_ptr_q == AW'(MAP_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          cmd_d      = req_i.data.cmd;
          live_d     = live_n;
          free_idx_d = PAGE_W'(off_idx);
          rd_ptr_d   = '0;
          rd_page_d  = '0;
          chk_vld_d  = 1'b0;
          res_addr_d = '0;
          if (req_i.data.cmd == CMD_FREE) begin
            if (bad_free) begin
              res_status_d = ST_BADADDR;
              state_d      = S_OUT;
            end else begin
              state_d = S_SCAN;
            end
          end else begin
            if (live_n == '0) begin
              res_status_d = ST_NOFREE;
              state_d      = S_OUT;
            end else begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_en) begin
          rd_ptr_d  = rd_ptr_q + AW'(1);
          rd_page_d = rd_page_q + EW'(MAP_WORD_BITS);
        end
        chk_vld_d  = rd_en;
        chk_ptr_d  = rd_ptr_q;
        chk_page_d = PAGE_W'(rd_page_q);
        if (chk_vld_q) begin
          if (flags.hit) begin
            ram_we       = 1'b1;
            res_status_d = ST_OK;
            if (cmd_q == CMD_ALLOC) begin
              res_addr_d = base_al
                         + ((32'(chk_page_q) + 32'(bit_pos)) << PAGE_SHIFT);
            end
            state_d = S_OUT;
          end else if (flags.last) begin
            res_status_d = ST_NOFREE;
            state_d      = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d        = 1'b1;
          rsp_d.status     = res_status_q;
          rsp_d.alloc_addr = res_addr_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      rd_ptr_q  <= '0;
      rd_page_q <= '0;
      chk_vld_q <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      rd_page_q <= rd_page_d;
      chk_vld_q <= chk_vld_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    live_q       <= live_d;
    free_idx_q   <= free_idx_d;
    chk_ptr_q    <= chk_ptr_d;
    chk_page_q   <= chk_page_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    rsp_q        <= rsp_d;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate and free requests through the request channel and checks
// every response against a cycle-free model of the page bitmap. A directed
// sequence covers wrap-around, alignment and range cases. Randomised phases
// then follow under several base and page count settings and several
// backpressure modes.
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;

  localparam int MAP_PAGES   = 4096;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 140;

  logic clk_i = 1'b0;
  logic rst_ni;

  bpa_stream_if #(.payload_t(bpa_cfg_t)) cfg_if ();
  bpa_stream_if #(.payload_t(bpa_req_t)) req_if ();
  bpa_stream_if #(.payload_t(bpa_rsp_t)) rsp_if ();

  bitmap_page_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  bit [MAP_PAGES-1:0] page_used;
  logic [ADDR_W-1:0]  cfg_base;
  logic [COUNT_W-1:0] cfg_count;

  bpa_req_t pending_reqs[$];
  bpa_rsp_t expected_rsps[$];
  bpa_rsp_t oldest_rsp;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned n_errors;
  int unsigned n_cycles;
  int unsigned n_accepted;
  int unsigned n_alloc_ok;
  int unsigned n_alloc_refused;
  int unsigned n_free_ok;
  int unsigned n_free_rejected;
  int unsigned n_reg_writes;

  function automatic bpa_rsp_t predict_page_op(bpa_req_t req);
    bpa_rsp_t rsp;
    logic [ADDR_W-1:0] base_al;
    logic [ADDR_W-1:0] idx;
    int unsigned live;
    rsp = '0;
    rsp.status = ST_OK;
    base_al = {cfg_base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    live = (cfg_count > MAP_PAGES) ? MAP_PAGES : cfg_count;
    if (req.cmd == CMD_ALLOC) begin
      rsp.status = ST_NOFREE;
      for (int i = 0; i < live; i++) begin
        if (!page_used[i]) begin
          page_used[i] = 1'b1;
          rsp.status = ST_OK;
          rsp.alloc_addr = base_al + (ADDR_W'(i) << PAGE_SHIFT);
          break;
        end
      end
    end else if (req.page_addr[PAGE_SHIFT-1:0] != '0 || req.page_addr < base_al) begin
      rsp.status = ST_BADADDR;
    end else begin
      idx = (req.page_addr - base_al) >> PAGE_SHIFT;
      if (idx >= live) begin
        rsp.status = ST_BADADDR;
      end else begin
        page_used[idx] = 1'b0;
      end
    end
    return rsp;
  endfunction

  // Request driver: predicts each accepted transaction and presents the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        oldest_rsp = predict_page_op(req_if.data);
        expected_rsps.push_back(oldest_rsp);
        n_accepted++;
        if (req_if.data.cmd == CMD_ALLOC) begin
          if (oldest_rsp.status == ST_OK) n_alloc_ok++;
          else n_alloc_refused++;
        end else begin
          if (oldest_rsp.status == ST_OK) n_free_ok++;
          else n_free_rejected++;
        end
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: status %0d, alloc_addr 0x%08h",
                 rsp_if.data.status, rsp_if.data.alloc_addr);
          n_errors++;
        end else begin
          oldest_rsp = expected_rsps.pop_front();
          if (rsp_if.data.status !== oldest_rsp.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   oldest_rsp.status, rsp_if.data.status);
            n_errors++;
          end
          if (rsp_if.data.alloc_addr !== oldest_rsp.alloc_addr) begin
            $error("alloc_addr mismatch: expected 0x%08h, actual 0x%08h",
                   oldest_rsp.alloc_addr, rsp_if.data.alloc_addr);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    bpa_cfg_t wr;
    wr.index = idx;
    wr.value = value;
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= wr;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_BASE_ADDR) cfg_base = value;
    else cfg_count = value[COUNT_W-1:0];
    n_reg_writes++;
  endtask

  task automatic push_req(input logic cmd, input logic [ADDR_W-1:0] addr);
    bpa_req_t req;
    req.cmd = cmd;
    req.page_addr = addr;
    pending_reqs.push_back(req);
  endtask

  task automatic set_pressure(input int mode);
    case (mode % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 66;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 66;
      end
      default: begin
        send_idle_pct = 11;
        recv_stall_pct = 11;
      end
    endcase
  endtask

  task automatic run_traffic(input logic [ADDR_W-1:0] base, input logic [COUNT_W-1:0] count,
                             input int mode, input int n_items);
    logic [ADDR_W-1:0] base_al;
    logic [ADDR_W-1:0] addr;
    int unsigned live;
    int unsigned pick;
    wait_drained();
    write_reg(CFG_BASE_ADDR, base);
    write_reg(CFG_PAGE_COUNT, ADDR_W'(count));
    set_pressure(mode);
    base_al = {base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    live = (count > MAP_PAGES) ? MAP_PAGES : count;
    for (int k = 0; k < n_items; k++) begin
      // Halfway through, the sender holds off until every response is back.
      if (k == n_items / 2) wait_drained();
      pick = $urandom_range(99);
      addr = base_al + (ADDR_W'($urandom_range(0, live)) << PAGE_SHIFT);
      if (pick < 50) begin
        push_req(CMD_ALLOC, $urandom);
      end else if (pick < 80) begin
        push_req(CMD_FREE, addr);
      end else if (pick < 88) begin
        push_req(CMD_FREE, addr | ADDR_W'($urandom_range(1, 4095)));
      end else begin
        push_req(CMD_FREE, $urandom);
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    logic [COUNT_W-1:0] count;
    rst_ni = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    page_used = '0;
    cfg_base = '0;
    cfg_count = '0;
    set_pressure(0);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With the reset settings no page is under management.
    push_req(CMD_ALLOC, 32'h0000_0000);
    push_req(CMD_FREE, 32'h0000_0000);
    wait_drained();

    // Unaligned base at the top of the address space, three pages.
    write_reg(CFG_BASE_ADDR, 32'hFFFF_EABC);
    write_reg(CFG_PAGE_COUNT, 32'd3);
    set_pressure(3);
    push_req(CMD_ALLOC, 32'h0000_0000);
    push_req(CMD_ALLOC, 32'hFFFF_FFFF);
    push_req(CMD_ALLOC, 32'h1234_5678);
    push_req(CMD_ALLOC, 32'h0000_0000);
    push_req(CMD_FREE, 32'hFFFF_F000);
    push_req(CMD_FREE, 32'hFFFF_F000);
    push_req(CMD_ALLOC, 32'h0000_0000);
    push_req(CMD_FREE, 32'hFFFF_E001);
    push_req(CMD_FREE, 32'h0000_0000);
    push_req(CMD_FREE, 32'hFFFF_D000);
    push_req(CMD_FREE, 32'hFFFF_FFFF);
    wait_drained();

    // A page count beyond the map is clipped to the full map.
    write_reg(CFG_BASE_ADDR, 32'h0000_0000);
    write_reg(CFG_PAGE_COUNT, 32'h0000_1FFF);
    set_pressure(1);
    push_req(CMD_FREE, 32'h00FF_F000);
    push_req(CMD_FREE, 32'h0100_0000);
    push_req(CMD_ALLOC, 32'h0000_0000);
    push_req(CMD_ALLOC, 32'hFFFF_FFFF);
    push_req(CMD_FREE, 32'h0000_1000);
    push_req(CMD_FREE, 32'h0000_0000);

    for (int p = 0; p < 13; p++) begin
      base = $urandom;
      case (p)
        0: begin
          base = base & 32'hFFFF_F000;
          count = 13'd1;
        end
        1: count = 13'd32;
        2: begin
          base = 32'h0000_0000;
          count = 13'd33;
        end
        3: begin
          base = 32'hFFFF_F000;
          count = 13'd64;
        end
        4: count = 13'd31;
        5: count = 13'd4096;
        6: count = 13'h1FFF;
        7: count = 13'd0;
        default: count = COUNT_W'($urandom_range(2, 200));
      endcase
      run_traffic(base, count, p, 100);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (expected_rsps.size() != 0) begin
      $error("%0d responses never arrived", expected_rsps.size());
      n_errors++;
    end
    $display("Checked %0d requests: %0d pages allocated, %0d allocations refused, %0d released, %0d frees rejected.",
             n_accepted, n_alloc_ok, n_alloc_refused, n_free_ok, n_free_rejected);
    $display("%0d register writes across wrap-around, clipped and empty page maps.",
             n_reg_writes);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
